// ===== rtl/core/soau_pkg.sv =====
// ----------------------------------------------------------------------------
// soau_pkg: shared types and constants of the operand access unit
// Item layouts, operation and descriptor codes, register indexes and the
// state encoding of the access sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package soau_pkg;

  localparam int MEM_BYTES_DEF  = 16384;
  localparam int SEGMENT_COUNT  = 8;
  localparam int REGISTER_COUNT = 32;
  localparam int REG_IDX_W      = 5;
  localparam int SIZE_W         = 17;
  localparam int CFG_W          = 15;

  localparam logic [REG_IDX_W-1:0] LAR_INDEX = 5'd1;
  localparam logic [REG_IDX_W-1:0] MAR_INDEX = 5'd2;
  localparam logic [REG_IDX_W-1:0] MBR_INDEX = 5'd3;
  localparam logic [REG_IDX_W-1:0] DS_INDEX  = 5'd27;
  localparam logic [31:0]          DS_RESET  = 32'h0001_0000;

  // operand accesses to memory always move one word
  localparam logic [2:0] OPND_BYTES = 3'd4;
  localparam logic [2:0] MAX_BYTES  = 3'd4;

  localparam logic [1:0] OP_RD_OPND = 2'd0;
  localparam logic [1:0] OP_WR_OPND = 2'd1;
  localparam logic [1:0] OP_RD_MEM  = 2'd2;
  localparam logic [1:0] OP_WR_MEM  = 2'd3;

  localparam logic [7:0] TYPE_REG = 8'd1;
  localparam logic [7:0] TYPE_IMM = 8'd2;
  localparam logic [7:0] TYPE_MEM = 8'd3;

  localparam logic [15:0] SEG_CODE = 16'd0;
  localparam logic [15:0] SEG_DATA = 16'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        operand_descriptor;
    logic [31:0]        logical_address;
    logic [2:0]         byte_count;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               access_ok;
    logic               running;
  } out_item_t;

  typedef struct packed {
    logic        fault;
    logic [15:0] phys;
  } xlate_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_CHECK,
    S_MEM,
    S_FIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/soau_xlate.sv =====
// ----------------------------------------------------------------------------
// soau_xlate: segment translation and bounds check
// Splits a logical address into segment and offset, checks offset and byte
// count against the segment size and forms the physical byte address.
// ----------------------------------------------------------------------------
`default_nettype none

module soau_xlate
  import soau_pkg::*;
(
  input  wire logic [31:0]       laddr,
  input  wire logic [2:0]        cnt,
  input  wire logic [SIZE_W-1:0] csz,
  input  wire logic [SIZE_W-1:0] dsz,
  output xlate_t                 res
);

  logic [15:0]       seg;
  logic [SIZE_W-1:0] off;
  logic [SIZE_W-1:0] cnt_w;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] base;
  logic [SIZE_W-1:0] phys_w;
  logic              is_code;
  logic              seg_ok;

  always_comb begin
    seg     = laddr[31:16];
    off     = {1'b0, laddr[15:0]};
    cnt_w   = SIZE_W'(cnt);
    is_code = (seg == SEG_CODE);
    seg_ok  = is_code || ((seg == SEG_DATA) && (SEGMENT_COUNT > 1));
    size    = is_code ? csz : dsz;
    base    = is_code ? '0 : csz;
    phys_w  = base + off;
    res.fault = !seg_ok || (off >= size) || (cnt == 3'd0) || (cnt > MAX_BYTES) ||
                (cnt_w > size) || ((off + cnt_w) > size);
    res.phys  = phys_w[15:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/segmented_operand_access_unit.sv =====
// ----------------------------------------------------------------------------
// segmented_operand_access_unit: operand and memory access unit
// Register, immediate and memory operands plus direct segmented memory
// accesses of one to four bytes, big-endian, one byte per cycle.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_item_t
//  out      output     out_valid/out_stall  out_item_t
//  cfg      input      cfg_valid/cfg_ready  code_size (15 bits)
//
// One item at a time. Register and immediate items pass through S_ADDR and
// S_DONE, faults go from S_CHECK to S_DONE, memory writes go on through S_MEM
// and memory reads through S_MEM and S_FIN: the byte-wide memory port moves one
// byte a cycle and read bytes come from a registered memory output.
// Synchronous active-low reset; memory contents are not cleared.
// A stalled result holds the next item in the sequencer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_operand_access_unit
  import soau_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [SIZE_W-1:0] MEM_SIZE = SIZE_W'(MEM_BYTES);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] csz_r, dsz_r;
  logic [SIZE_W-1:0] cfg_w;
  logic [SIZE_W-1:0] csz_nxt;

  logic [31:0] rf_r [REGISTER_COUNT];

  logic [1:0]  op_r;
  logic [31:0] desc_r;
  logic [31:0] laddr_r;
  logic [2:0]  cnt_r;
  logic [31:0] wval_r;
  logic        is_rd_r;
  logic [15:0] phys_r;
  logic [1:0]  idx_r;
  logic [31:0] wsh_r;
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] rval_r;
  logic        ok_r;
  logic        run_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_r;
  logic          rd_pend_r;
  logic [AW-1:0] mem_addr;

  logic [7:0]  desc_type;
  logic [31:0] rf_rd;
  logic [31:0] disp;
  logic [31:0] opnd_addr;
  logic        last_byte;
  logic        out_free;
  logic        in_take;
  xlate_t      xl;

  soau_xlate u_xlate (
    .laddr (laddr_r),
    .cnt   (cnt_r),
    .csz   (csz_r),
    .dsz   (dsz_r),
    .res   (xl)
  );

  always_comb begin
    desc_type = desc_r[31:24];
    rf_rd     = rf_r[desc_r[REG_IDX_W-1:0]];
    disp      = {{16{desc_r[23]}}, desc_r[23:8]};
    opnd_addr = rf_rd + disp;
    last_byte = (idx_r == (cnt_r[1:0] - 2'd1));
    mem_addr  = phys_r[AW-1:0] + AW'(idx_r);
    acc_nxt   = {acc_r[23:0], rdata_r};
    out_free  = !out_valid_r || !out_stall;
    in_take   = in_valid && !in_stall;
    cfg_w     = SIZE_W'(cfg_data);
    csz_nxt   = (cfg_w > MEM_SIZE) ? MEM_SIZE : cfg_w;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_RD_OPND: begin
            if (desc_type != TYPE_REG && desc_type != TYPE_IMM) begin
              state_nxt = S_CHECK;
            end
          end
          OP_WR_OPND: begin
            if (desc_type == TYPE_MEM) begin
              state_nxt = S_CHECK;
            end
          end
          default: state_nxt = S_CHECK;
        endcase
      end
      S_CHECK: state_nxt = xl.fault ? S_DONE : S_MEM;
      S_MEM: begin
        if (last_byte) begin
          state_nxt = is_rd_r ? S_FIN : S_DONE;
        end
      end
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csz_r <= '0;
      dsz_r <= MEM_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      csz_r <= csz_nxt;
      dsz_r <= MEM_SIZE - csz_nxt;
    end
  end

  // register file with bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        rf_r[i] <= (REG_IDX_W'(i) == DS_INDEX) ? DS_RESET : 32'd0;
      end
    end else begin
      unique case (state_r)
        S_ADDR: begin
          if (op_r == OP_WR_OPND && desc_type == TYPE_REG) begin
            rf_r[desc_r[REG_IDX_W-1:0]] <= wval_r;
          end
        end
        S_CHECK: begin
          rf_r[LAR_INDEX] <= laddr_r;
          rf_r[MAR_INDEX] <= {13'd0, cnt_r, xl.fault ? 16'd0 : xl.phys};
          if (!xl.fault && !is_rd_r) begin
            rf_r[MBR_INDEX] <= wval_r;
          end
        end
        S_FIN: rf_r[MBR_INDEX] <= acc_nxt;
        default: ;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_r    <= in_data.op;
          desc_r  <= in_data.operand_descriptor;
          laddr_r <= in_data.logical_address;
          cnt_r   <= in_data.byte_count;
          wval_r  <= in_data.write_value;
        end
      end
      S_ADDR: begin
        is_rd_r <= (op_r == OP_RD_OPND) || (op_r == OP_RD_MEM);
        if (op_r == OP_RD_OPND || op_r == OP_WR_OPND) begin
          laddr_r <= opnd_addr;
          cnt_r   <= OPND_BYTES;
        end
        if (op_r == OP_RD_OPND && desc_type == TYPE_REG) begin
          rval_r <= rf_rd;
          ok_r   <= 1'b1;
        end else if (op_r == OP_RD_OPND && desc_type == TYPE_IMM) begin
          rval_r <= {{16{desc_r[15]}}, desc_r[15:0]};
          ok_r   <= 1'b1;
        end else if (op_r == OP_WR_OPND && desc_type == TYPE_REG) begin
          rval_r <= 32'd0;
          ok_r   <= 1'b1;
        end else begin
          rval_r <= 32'd0;
          ok_r   <= 1'b0;
        end
      end
      S_CHECK: begin
        phys_r <= xl.phys;
        idx_r  <= 2'd0;
        ok_r   <= !xl.fault;
        // left-align the stored bytes so the first byte out is the top one
        unique case (cnt_r)
          3'd1:    wsh_r <= {wval_r[7:0], 24'd0};
          3'd2:    wsh_r <= {wval_r[15:0], 16'd0};
          3'd3:    wsh_r <= {wval_r[23:0], 8'd0};
          default: wsh_r <= wval_r;
        endcase
      end
      S_MEM: begin
        idx_r <= idx_r + 2'd1;
        wsh_r <= {wsh_r[23:0], 8'd0};
      end
      S_FIN:   rval_r <= acc_nxt;
      default: ;
    endcase
  end

  // read bytes shift in one per cycle behind the memory latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_MEM) && is_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      acc_r <= 32'd0;
    end else if (rd_pend_r) begin
      acc_r <= acc_nxt;
    end
  end

  // byte memory
  always_ff @(posedge clk) begin
    if (state_r == S_MEM) begin
      if (is_rd_r) begin
        rdata_r <= mem[mem_addr];
      end else begin
        mem[mem_addr] <= wsh_r[31:24];
      end
    end
  end

  // running flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b1;
    end else if (state_r == S_CHECK && xl.fault) begin
      run_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_r.read_value <= rval_r;
      out_r.access_ok  <= ok_r;
      out_r.running    <= run_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/soau_checker.sv =====
// ----------------------------------------------------------------------------
// soau_checker: port-level checks of the operand access unit
// Observes the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module soau_checker
  import soau_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in progress");

  // a failed access never returns data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.access_ok |-> out_data.read_value == 32'sd0)
    else $error("failed access returned nonzero data");

  // once stopped, only reset restarts the machine
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.running |=> !(out_valid && out_data.running))
    else $error("running flag set again without reset");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segmented_operand_access_unit soau_checker u_soau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
